// ===== hdl/ffsa_pkg.sv =====
// Shared types and constants for the first-fit segment allocator.
`timescale 1ns / 1ps
package ffsa_pkg;
  localparam int MaxSegments = 64;
  localparam int AddrBits = 32;
  localparam int CntBits = $clog2(MaxSegments + 1);
  localparam int IdxBits = $clog2(MaxSegments);
  localparam logic [31:0] ChunkReset = 32'd1048576;

  typedef enum logic [2:0] {
    ST_GRANTED = 3'd0,
    ST_NO_FIT = 3'd1,
    ST_RELEASED = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_ZERO_SIZE = 3'd4,
    ST_FULL = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } cell_op_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic [3:0] align_log2;
    logic [AddrBits-1:0] size;
    logic [AddrBits-1:0] key;
    cell_op_t op;
    logic [CntBits-1:0] pos;
    logic [AddrBits-1:0] new_start;
  } cell_ctl_t;

  function automatic logic [AddrBits:0] round_up(input logic [AddrBits:0] v,
                                                 input logic [3:0] lg);
    logic [AddrBits:0] m;
    m = ({{AddrBits{1'b0}}, 1'b1} << lg) - 1'b1;
    return (v + m) & ~m;
  endfunction
endpackage

// ===== hdl/ffsa_if.sv =====
// Valid/ready channel interfaces for request and result transactions.
`timescale 1ns / 1ps
interface ffsa_req_if;
  logic valid;
  logic ready;
  logic req_type;
  logic [31:0] req_bytes;
  logic [3:0] align_log2;
  logic [31:0] release_offset;
  modport source(output valid, req_type, req_bytes, align_log2, release_offset, input ready);
  modport sink(input valid, req_type, req_bytes, align_log2, release_offset, output ready);
endinterface

interface ffsa_rsp_if;
  logic valid;
  logic ready;
  logic [2:0] status;
  logic [31:0] grant_offset;
  logic [31:0] freed_bytes;
  logic [6:0] segment_count;
  modport source(output valid, status, grant_offset, freed_bytes, segment_count, input ready);
  modport sink(input valid, status, grant_offset, freed_bytes, segment_count, output ready);
endinterface

// ===== hdl/first_fit_segment_allocator_unit.sv =====
// Top level: request/result channels, APB config, cell chain and controller.
// Usage:
//   in   : request (req_type 0, req_bytes, align_log2) or release
//          (req_type 1, release_offset) transactions, valid/ready.
//   out  : one result transaction per request or release: status, grant_offset,
//          freed_bytes, segment_count.
//   cfg  : APB register 0 at address 0 is chunk_size (reset 1 MiB).
// Timing: a transaction is captured at the accepting edge, the cell chain
//   evaluates all gaps and matches in the next cycle and updates the table
//   at its end, and the result is offered from the following cycle on. With
//   out_ready high it is taken when first offered, and a new transaction is
//   accepted only once the unit is idle again: in_ready is high only while
//   idle, so one transaction is in work at a time.
// Reset: segment count goes to zero, chunk_size to its reset value; the
//   table contents need no clearing.
// Stall: when out_ready is low the result is held in the output register
//   and in_ready stays low until it is taken.
`timescale 1ns / 1ps
module first_fit_segment_allocator_unit
  import ffsa_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  ffsa_req_if.sink in_ch,
  ffsa_rsp_if.source out_ch,
  input  logic cfg_psel,
  input  logic cfg_penable,
  input  logic cfg_pwrite,
  input  logic [0:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic cfg_pready
);
  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_OUT} state_t;
  state_t state_r;
  logic [31:0] chunk_r;
  logic [CntBits-1:0] used_r;
  logic rtype_r;
  logic [3:0] lg_r;
  logic [AddrBits-1:0] size_r, key_r;
  logic [2:0] st_r;
  logic [31:0] goff_r, freed_r;

  logic [AddrBits-1:0] st_q [MaxSegments];
  logic [AddrBits-1:0] ln_q [MaxSegments];
  logic [AddrBits-1:0] gf [MaxSegments];
  logic [MaxSegments-1:0] fit_v, hit_v;
  cell_ctl_t ctl;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = chunk_r;
  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.status = st_r;
  assign out_ch.grant_offset = goff_r;
  assign out_ch.freed_bytes = freed_r;
  assign out_ch.segment_count = 7'(used_r);

  genvar g;
  generate
    for (g = 0; g < MaxSegments; g++) begin : g_cell
      ffsa_cell u_cell (
        .clk(clk), .my_idx(CntBits'(g)), .ctl(ctl),
        .prev_start(st_q[(g == 0) ? 0 : g-1]), .prev_len(ln_q[(g == 0) ? 0 : g-1]),
        .next_start(st_q[(g == MaxSegments-1) ? g : g+1]),
        .next_len(ln_q[(g == MaxSegments-1) ? g : g+1]),
        .start_q(st_q[g]), .len_q(ln_q[g]), .gap_from(gf[g]),
        .fits(fit_v[g]), .hit(hit_v[g])
      );
    end
  endgenerate

  // First valid cell that fits / matches.
  logic [MaxSegments-1:0] fit_m, hit_m;
  logic fit_any, hit_any;
  logic [IdxBits-1:0] fit_i, hit_i;
  logic [AddrBits:0] tail_from;
  logic tail_fits;
  logic [IdxBits-1:0] last_i;
  always_comb begin
    for (int k = 0; k < MaxSegments; k++) begin
      fit_m[k] = fit_v[k] && (CntBits'(k) < used_r);
      hit_m[k] = hit_v[k] && (CntBits'(k) < used_r);
    end
    fit_any = |fit_m;
    hit_any = |hit_m;
    fit_i = '0;
    hit_i = '0;
    for (int k = MaxSegments-1; k >= 0; k--) begin
      if (fit_m[k]) fit_i = IdxBits'(k);
      if (hit_m[k]) hit_i = IdxBits'(k);
    end
    last_i = IdxBits'(used_r - 1'b1);
    if (used_r == '0) begin
      tail_from = '0;
    end else begin
      tail_from = round_up({1'b0, st_q[last_i]} + {1'b0, ln_q[last_i]}, lg_r);
    end
    tail_fits = ({1'b0, chunk_r} > tail_from) &&
                (({1'b0, chunk_r} - tail_from) >= {1'b0, size_r});
  end

  always_comb begin
    ctl.align_log2 = lg_r;
    ctl.size = size_r;
    ctl.key = key_r;
    ctl.op = OP_HOLD;
    ctl.pos = used_r;
    ctl.new_start = tail_from[AddrBits-1:0];
    if (state_r == S_EXEC) begin
      if (rtype_r) begin
        if (hit_any) begin
          ctl.op = OP_REMOVE;
          ctl.pos = CntBits'(hit_i);
        end
      end else if (size_r != '0 && used_r < CntBits'(MaxSegments)) begin
        if (fit_any) begin
          ctl.op = OP_INSERT;
          ctl.pos = CntBits'(fit_i);
          ctl.new_start = gf[fit_i];
        end else if (tail_fits) begin
          ctl.op = OP_INSERT;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      chunk_r <= ChunkReset;
      used_r <= '0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 1'b0) begin
        chunk_r <= cfg_pwdata;
      end
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            rtype_r <= in_ch.req_type;
            size_r <= in_ch.req_bytes;
            lg_r <= in_ch.align_log2;
            key_r <= in_ch.release_offset;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          goff_r <= '0;
          freed_r <= '0;
          state_r <= S_OUT;
          if (rtype_r) begin
            if (hit_any) begin
              st_r <= ST_RELEASED;
              freed_r <= ln_q[hit_i];
              used_r <= used_r - 1'b1;
            end else begin
              st_r <= ST_NOT_FOUND;
            end
          end else if (size_r == '0) begin
            st_r <= ST_ZERO_SIZE;
          end else if (used_r >= CntBits'(MaxSegments)) begin
            st_r <= ST_FULL;
          end else if (ctl.op == OP_INSERT) begin
            st_r <= ST_GRANTED;
            goff_r <= ctl.new_start;
            used_r <= used_r + 1'b1;
          end else begin
            st_r <= ST_NO_FIT;
          end
        end
        S_OUT: begin
          if (out_ch.ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CntBits'(MaxSegments)) else $error("count overflow");
  a_grant_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && ctl.op == OP_INSERT) |=> used_r == $past(used_r) + 1'b1)
    else $error("insert did not grow count");
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid)) else $error("accept while result pending");
`endif
endmodule

// ===== hdl/ffsa_cell.sv =====
// One table cell: holds a segment, evaluates the gap below it, shifts on insert/remove.
`timescale 1ns / 1ps
module ffsa_cell
  import ffsa_pkg::*;
(
  input  logic clk,
  input  logic [CntBits-1:0] my_idx,
  input  cell_ctl_t ctl,
  input  logic [AddrBits-1:0] prev_start,
  input  logic [AddrBits-1:0] prev_len,
  input  logic [AddrBits-1:0] next_start,
  input  logic [AddrBits-1:0] next_len,
  output logic [AddrBits-1:0] start_q,
  output logic [AddrBits-1:0] len_q,
  output logic [AddrBits-1:0] gap_from,
  output logic fits,
  output logic hit
);
  logic [AddrBits-1:0] start_r, len_r;
  logic [AddrBits:0] from_w;

  always_comb begin
    if (my_idx == '0) begin
      from_w = '0;
    end else begin
      from_w = round_up({1'b0, prev_start} + {1'b0, prev_len}, ctl.align_log2);
    end
    fits = ({1'b0, start_r} > from_w) && (({1'b0, start_r} - from_w) >= {1'b0, ctl.size});
    gap_from = from_w[AddrBits-1:0];
    hit = (start_r == ctl.key);
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_INSERT: begin
        if (my_idx == ctl.pos) begin
          start_r <= ctl.new_start;
          len_r <= ctl.size;
        end else if (my_idx > ctl.pos) begin
          start_r <= prev_start;
          len_r <= prev_len;
        end
      end
      OP_REMOVE: begin
        if (my_idx >= ctl.pos) begin
          start_r <= next_start;
          len_r <= next_len;
        end
      end
      default: begin
      end
    endcase
  end

  assign start_q = start_r;
  assign len_q = len_r;
endmodule
